/* hw/rtl/wcwt_pkg.sv */
package wcwt_pkg;

   // default sizes
   localparam int SLOTS_DEF      = 16;
   localparam int COUNT_BITS_DEF = 32;

   // field widths of the item channels
   localparam int CMD_W    = 2;
   localparam int AMOUNT_W = 32;
   localparam int FIBER_W  = 16;
   localparam int TAG_W    = 8;
   localparam int TARGET_W = 32;
   localparam int KIND_W   = 3;
   localparam int PREV_W   = 32;

   // command codes
   localparam logic [CMD_W-1:0] CMD_INC  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_DEC  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_WAIT = 2'd2;

   // result kinds
   localparam logic [KIND_W-1:0] KIND_RELEASE   = 3'd0;
   localparam logic [KIND_W-1:0] KIND_DONE      = 3'd1;
   localparam logic [KIND_W-1:0] KIND_QUEUED    = 3'd2;
   localparam logic [KIND_W-1:0] KIND_SATISFIED = 3'd3;
   localparam logic [KIND_W-1:0] KIND_FULL      = 3'd4;

   typedef struct packed {
      logic [CMD_W-1:0]    cmd;
      logic [AMOUNT_W-1:0] amount;
      logic [FIBER_W-1:0]  fiber_index;
      logic [TAG_W-1:0]    wake_tag;
      logic [TARGET_W-1:0] target_value;
   } req_type;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [PREV_W-1:0]  prev_value;
      logic [FIBER_W-1:0] released_fiber;
      logic [TAG_W-1:0]   released_tag;
      logic               last;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINAL,
      ST_FIND
   } state_type;

endpackage

/* hw/rtl/wcwt_ram.sv */
module wcwt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/wcwt_alu.sv */
module wcwt_alu #(
   parameter int COUNT_BITS = 32
) (
   input  logic                  sub,
   input  logic [COUNT_BITS-1:0] add_a,
   input  logic [COUNT_BITS-1:0] add_b,
   input  logic [COUNT_BITS-1:0] cmp_a,
   input  logic [COUNT_BITS-1:0] cmp_b,
   output logic [COUNT_BITS-1:0] sum,
   output logic                  eq
);

   // wrapping add or subtract of the counter
   assign sum = sub ? (add_a - add_b) : (add_a + add_b);

   // the one target compare, shared by the release walk and the wait check
   assign eq = (cmp_a == cmp_b);

endmodule

/* hw/rtl/wait_counter_waiter_table.sv */
// Synchronization counter with SLOTS waiter slots. An increment or decrement
// item is accepted and updates the counter; the sequencer then walks the slot
// RAM slot by slot through its single read port and compares each target with
// the new count, releasing matches in ascending slot order, and closes with a
// count-done item. A wait item walks busy bits up to the lowest free slot. A
// result held back on the rsp side stalls the sequencer until it is taken.
// An item with command code 3 is accepted and dropped. Busy bits are
// flip-flops cleared by reset, so no clearing pass runs over the slot RAM.
module wait_counter_waiter_table
   import wcwt_pkg::*;
#(
   parameter int SLOTS      = SLOTS_DEF,
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);

   localparam int IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int ENTRY_W = FIBER_W + TAG_W + COUNT_BITS;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

   state_type             state_ff, state_in;
   logic [IDX_W-1:0]      scan_ff, scan_in;
   logic [SLOTS-1:0]      busy_ff, busy_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [COUNT_BITS-1:0] prev_ff, prev_in;
   logic [FIBER_W-1:0]    fiber_ff, fiber_in;
   logic [TAG_W-1:0]      tag_ff, tag_in;
   logic [COUNT_BITS-1:0] target_ff, target_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   logic                  wr_en;
   logic [ENTRY_W-1:0]    wr_data;
   logic [ENTRY_W-1:0]    rd_data;
   logic [FIBER_W-1:0]    rd_fiber;
   logic [TAG_W-1:0]      rd_tag;
   logic [COUNT_BITS-1:0] rd_target;

   logic                  alu_sub;
   logic [COUNT_BITS-1:0] alu_amount;
   logic [COUNT_BITS-1:0] alu_cmp_a;
   logic [COUNT_BITS-1:0] alu_sum;
   logic                  alu_eq;

   logic                  can_load;
   logic                  cur_busy;
   logic                  req_fire;

   // slot entries: fiber, tag and target
   wcwt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (SLOTS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (scan_ff),
      .wr_data (wr_data),
      .rd_addr (scan_in),
      .rd_data (rd_data)
   );

   assign rd_fiber  = rd_data[ENTRY_W-1 -: FIBER_W];
   assign rd_tag    = rd_data[COUNT_BITS +: TAG_W];
   assign rd_target = rd_data[COUNT_BITS-1:0];
   assign wr_data   = {fiber_ff, tag_ff, target_ff};

   // shared add and compare unit
   assign alu_sub    = (req_payload.cmd == CMD_DEC);
   assign alu_amount = COUNT_BITS'(req_payload.amount);
   assign alu_cmp_a  = (state_ff == ST_FIND) ? target_ff : rd_target;

   wcwt_alu #(
      .COUNT_BITS (COUNT_BITS)
   ) u_alu (
      .sub   (alu_sub),
      .add_a (count_ff),
      .add_b (alu_amount),
      .cmp_a (alu_cmp_a),
      .cmp_b (count_ff),
      .sum   (alu_sum),
      .eq    (alu_eq)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign can_load  = !rsp_valid_ff || rsp_ready;
   assign cur_busy  = busy_ff[scan_ff];

   // sequencer: next state, slot walk and result loading
   always_comb begin
      state_in     = state_ff;
      scan_in      = scan_ff;
      busy_in      = busy_ff;
      count_in     = count_ff;
      prev_in      = prev_ff;
      fiber_in     = fiber_ff;
      tag_in       = tag_ff;
      target_in    = target_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            scan_in = '0;
            if (req_fire) begin
               fiber_in  = req_payload.fiber_index;
               tag_in    = req_payload.wake_tag;
               target_in = COUNT_BITS'(req_payload.target_value);
               if (req_payload.cmd == CMD_INC || req_payload.cmd == CMD_DEC) begin
                  prev_in  = count_ff;
                  count_in = alu_sum;
                  state_in = ST_SCAN;
               end else if (req_payload.cmd == CMD_WAIT) begin
                  state_in = ST_FIND;
               end
            end
         end
         ST_SCAN: begin
            if (cur_busy && alu_eq) begin
               // matching waiter, release it once the output is free
               if (can_load) begin
                  rsp_valid_in               = 1'b1;
                  rsp_in.kind                = KIND_RELEASE;
                  rsp_in.prev_value          = '0;
                  rsp_in.released_fiber      = rd_fiber;
                  rsp_in.released_tag        = rd_tag;
                  rsp_in.last                = 1'b0;
                  busy_in[scan_ff]           = 1'b0;
                  if (scan_ff == LAST_IDX) begin
                     state_in = ST_FINAL;
                  end else begin
                     scan_in = scan_ff + 1'b1;
                  end
               end
            end else if (scan_ff == LAST_IDX) begin
               state_in = ST_FINAL;
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end
         ST_FINAL: begin
            if (can_load) begin
               rsp_valid_in          = 1'b1;
               rsp_in.kind           = KIND_DONE;
               rsp_in.prev_value     = PREV_W'(prev_ff);
               rsp_in.released_fiber = '0;
               rsp_in.released_tag   = '0;
               rsp_in.last           = 1'b1;
               state_in              = ST_IDLE;
            end
         end
         ST_FIND: begin
            if (!cur_busy || scan_ff == LAST_IDX) begin
               if (can_load) begin
                  rsp_valid_in          = 1'b1;
                  rsp_in.prev_value     = '0;
                  rsp_in.released_fiber = '0;
                  rsp_in.released_tag   = '0;
                  rsp_in.last           = 1'b1;
                  state_in              = ST_IDLE;
                  if (cur_busy) begin
                     rsp_in.kind = KIND_FULL;
                  end else if (alu_eq) begin
                     rsp_in.kind = KIND_SATISFIED;
                  end else begin
                     rsp_in.kind      = KIND_QUEUED;
                     wr_en            = 1'b1;
                     busy_in[scan_ff] = 1'b1;
                  end
               end
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         scan_ff      <= '0;
         busy_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scan_ff      <= scan_in;
         busy_ff      <= busy_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      prev_ff   <= prev_in;
      fiber_ff  <= fiber_in;
      tag_ff    <= tag_in;
      target_ff <= target_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

/* hw/rtl/wcwt_checker.sv */
module wcwt_checker
   import wcwt_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_payload,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_payload
);

   // a held result keeps its value
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("rsp item changed while stalled");

   // a counting or wait item leaves the block not ready in the cycle after it is taken
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready &&
      (req_payload.cmd == CMD_INC || req_payload.cmd == CMD_DEC ||
       req_payload.cmd == CMD_WAIT) |=> !req_ready)
      else $error("block ready right after taking an item");

   // only releases are non-final
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.last == (rsp_payload.kind != KIND_RELEASE)))
      else $error("last flag does not match result kind");

   // unused fields read as zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.kind != KIND_RELEASE |->
      rsp_payload.released_fiber == '0 && rsp_payload.released_tag == '0 &&
      (rsp_payload.kind == KIND_DONE || rsp_payload.prev_value == '0))
      else $error("unused result field not zero");

   // a pending release means the count-done item is still to come
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.kind == KIND_RELEASE |-> !req_ready)
      else $error("block idle with a release outstanding");

endmodule

bind wait_counter_waiter_table wcwt_checker u_checker (.*);
